>>> rtl/core/pvm_pkg.sv
// Shared types, codes and constants for the polyphonic sine voice mixer.
// Holds the note frequency table and its lookup function.
// No dependencies; every other file in rtl/core except pvm_ram uses it.
`default_nettype none

package pvm_pkg;

   // Input opcodes
   localparam logic OP_TICK        = 1'b0;
   localparam logic OP_VOICE_WRITE = 1'b1;

   // Configuration register indexes
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 28;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RATE_SCALE    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BUFFER_LENGTH = 2'd1;

   localparam logic [27:0] RATE_SCALE_RESET    = 28'd24932236;
   localparam logic [12:0] BUFFER_LENGTH_RESET = 13'd512;
   localparam logic [12:0] BUFFER_LENGTH_MAX   = 13'd4096;

   // Default sizes
   localparam int VOICE_COUNT_DEF     = 16;
   localparam int PHASE_BITS_DEF      = 32;
   localparam int SINE_TABLE_BITS_DEF = 10;

   // Shared multiplier operand width
   localparam int MUL_BITS  = 32;
   localparam int FREQ_BITS = 22;
   // rate_scale is multiplied in two halves split at this bit
   localparam int RATE_SPLIT = 14;

   // Sine polynomial coefficients (Q15 domain)
   localparam logic [15:0] SIN_A = 16'd51472;
   localparam logic [15:0] SIN_B = 16'd21024;
   localparam logic [15:0] SIN_C = 16'd2320;
   localparam logic [15:0] SINE_PEAK = 16'd32767;

   // Voice term divides by 81280 = 128 * 635: shift, then reciprocal multiply.
   // x < 2^31 and the reciprocal error is below 2^10, so the quotient is exact.
   localparam int TERM_PRE_SHIFT   = 7;
   localparam int TERM_ODD         = 635;
   localparam int TERM_RECIP_SHIFT = 41;
   localparam longint unsigned TERM_RECIP_WIDE =
      ((64'd1 << TERM_RECIP_SHIFT) + 64'(TERM_ODD) - 64'd1) / 64'(TERM_ODD);
   localparam logic [31:0] TERM_RECIP = 32'(TERM_RECIP_WIDE);

   localparam logic signed [31:0] ONE_Q24 = 32'sd16777216;

   // Top octave (notes 120..131) in Q8 Hz
   localparam logic [FREQ_BITS-1:0] TOP_OCTAVE_Q8 [12] = '{
      22'd2143237, 22'd2270680, 22'd2405702, 22'd2548752,
      22'd2700309, 22'd2860878, 22'd3030994, 22'd3211227,
      22'd3402176, 22'd3604480, 22'd3818814, 22'd4045892
   };

   typedef struct packed {
      logic        opcode;
      logic [3:0]  voice_slot;
      logic [6:0]  note_number;
      logic [6:0]  note_velocity;
      logic [15:0] instrument_gain;
      logic        voice_active;
   } req_type;

   typedef struct packed {
      logic signed [15:0] pcm_sample;
      logic               end_of_buffer;
   } rsp_type;

   // Hand-off from the voice sequencer to the output stage
   typedef struct packed {
      logic               emit;
      logic signed [31:0] sum;
   } mix_req_type;

   // Note frequency in Q8: top-octave entry shifted down by octave, round half up.
   // octave = note / 12 via (note * 171) >> 11, exact for note < 128.
   function automatic logic [FREQ_BITS-1:0] note_freq_q8(input logic [6:0] note);
      logic [14:0] scaled;
      logic [3:0]  octave;
      logic [3:0]  semi;
      logic [3:0]  sh;
      logic [22:0] base;
      logic [22:0] rnd;
      scaled = 15'(note) * 15'd171;
      octave = scaled[14:11];
      semi   = 4'(note - 7'({3'd0, octave}) * 7'd12);
      sh     = 4'd10 - octave;
      base   = {1'b0, TOP_OCTAVE_Q8[semi]};
      if (sh == 4'd0) begin
         rnd = 23'd0;
      end else begin
         rnd = 23'd1 << (sh - 4'd1);
      end
      return FREQ_BITS'((base + rnd) >> sh);
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/polyphonic_sine_voice_mixer_unit.sv
// Top level of the polyphonic sine voice mixer: voice table RAM, voice
// sequencer and configuration registers. Uses pvm_pkg, pvm_ram, pvm_mul
// and pvm_out_stage.
`default_nettype none

// An item is taken when start is high and busy is low. A voice write to a
// slot inside the table holds busy through the ST_W_UPD state after it is
// taken. A sample tick holds busy while it walks the voice table: each
// active voice goes through nine operations on one shared 32x32 multiplier
// plus a read and a write-back of the voice table, and inactive voices cost
// only a read each. The sample appears on rsp_data for the one cycle that
// rsp_valid is high, which is the first cycle with busy low; the receiver
// must take it then, there is no back-pressure. Reset needs no clearing pass.
module polyphonic_sine_voice_mixer_unit #(
   parameter int VOICE_COUNT     = pvm_pkg::VOICE_COUNT_DEF,
   parameter int PHASE_BITS      = pvm_pkg::PHASE_BITS_DEF,
   parameter int SINE_TABLE_BITS = pvm_pkg::SINE_TABLE_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire pvm_pkg::req_type                     req_data,
   output logic                                      rsp_valid,
   output pvm_pkg::rsp_type                          rsp_data,
   input  wire logic                                 csr_we,
   input  wire logic [pvm_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [pvm_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int VA        = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
   localparam int ENTRY_W   = PHASE_BITS + 31;
   localparam int ACT_POS   = PHASE_BITS;
   localparam int GAIN_LO   = PHASE_BITS + 1;
   localparam int VEL_LO    = PHASE_BITS + 17;
   localparam int NOTE_LO   = PHASE_BITS + 24;
   localparam int QUAD_BITS = SINE_TABLE_BITS - 2;
   localparam int U_SHIFT   = 15 - QUAD_BITS;
   localparam int INC_SHIFT = 48 - PHASE_BITS;
   localparam int MW        = pvm_pkg::MUL_BITS;
   localparam logic [VA-1:0] LAST_VOICE = VA'(VOICE_COUNT - 1);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_W_UPD = 4'd1;
   localparam logic [3:0] ST_T_LD  = 4'd2;
   localparam logic [3:0] ST_UU    = 4'd3;
   localparam logic [3:0] ST_CU    = 4'd4;
   localparam logic [3:0] ST_TU2   = 4'd5;
   localparam logic [3:0] ST_TU    = 4'd6;
   localparam logic [3:0] ST_YV    = 4'd7;
   localparam logic [3:0] ST_PG    = 4'd8;
   localparam logic [3:0] ST_DIV   = 4'd9;
   localparam logic [3:0] ST_FL    = 4'd10;
   localparam logic [3:0] ST_FH    = 4'd11;
   localparam logic [3:0] ST_WB    = 4'd12;
   localparam logic [3:0] ST_EMIT  = 4'd13;

   // control state
   logic [3:0]               state_ff, state_in;
   logic [VA-1:0]            vidx_ff, vidx_in;
   logic [VOICE_COUNT-1:0]   valid_ff, valid_in;
   logic signed [31:0]       acc_ff, acc_in;
   logic [27:0]              rate_scale_ff, rate_scale_in;
   logic [12:0]              buffer_length_ff, buffer_length_in;

   // per-voice working registers
   pvm_pkg::req_type              req_ff, req_in;
   logic [PHASE_BITS-1:0]         phase_ff, phase_in;
   logic [6:0]                    note_ff, note_in;
   logic [6:0]                    vel_ff, vel_in;
   logic [15:0]                   gain_ff, gain_in;
   logic [15:0]                   u_ff, u_in;
   logic [15:0]                   u2_ff, u2_in;
   logic                          neg_ff, neg_in;
   logic [pvm_pkg::FREQ_BITS-1:0] freq_ff, freq_in;
   logic [35:0]                   pl_ff, pl_in;

   // RAM and multiplier
   logic                 ram_we;
   logic [VA-1:0]        ram_raddr;
   logic [ENTRY_W-1:0]   ram_wdata;
   logic [ENTRY_W-1:0]   ram_rdata;
   logic [MW-1:0]        mul_a, mul_b;
   logic [2*MW-1:0]      prod;

   pvm_pkg::mix_req_type mix;

   // decoded entry
   logic [ENTRY_W-1:0]          entry;
   logic [PHASE_BITS-1:0]       ent_phase;
   logic                        ent_active;
   logic [15:0]                 ent_gain;
   logic [6:0]                  ent_vel;
   logic [6:0]                  ent_note;
   logic [SINE_TABLE_BITS-1:0]  sidx;
   logic [QUAD_BITS-1:0]        sfrac;
   logic [1:0]                  quad;
   logic [15:0]                 u_raw;
   logic [15:0]                 u_fold;

   logic [15:0]            p15;
   logic [15:0]            y_clamp;
   logic [21:0]            term_mag;
   logic [49:0]            inc_full;
   logic [PHASE_BITS-1:0]  inc;
   logic                   start_clear;
   logic [PHASE_BITS-1:0]  new_phase;
   logic                   slot_ok;

   pvm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (VOICE_COUNT)
   ) u_voice_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (vidx_ff),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   pvm_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   pvm_out_stage u_out (
      .clock         (clock),
      .reset         (reset),
      .mix           (mix),
      .buffer_length (buffer_length_ff),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data)
   );

   // read data always belongs to vidx_ff when it is consumed
   assign entry      = valid_ff[vidx_ff] ? ram_rdata : '0;
   assign ent_phase  = entry[PHASE_BITS-1:0];
   assign ent_active = entry[ACT_POS];
   assign ent_gain   = entry[GAIN_LO +: 16];
   assign ent_vel    = entry[VEL_LO +: 7];
   assign ent_note   = entry[NOTE_LO +: 7];

   assign sidx   = ent_phase[PHASE_BITS-1 -: SINE_TABLE_BITS];
   assign sfrac  = sidx[QUAD_BITS-1:0];
   assign quad   = sidx[SINE_TABLE_BITS-1 -: 2];
   assign u_raw  = 16'(sfrac) << U_SHIFT;
   assign u_fold = quad[0] ? 16'(17'd32768 - {1'b0, u_raw}) : u_raw;

   assign p15      = prod[30:15];
   assign y_clamp  = (p15 > pvm_pkg::SINE_PEAK) ? pvm_pkg::SINE_PEAK : p15;
   assign term_mag = prod[62:41];
   assign inc_full = (50'(prod[35:0]) << pvm_pkg::RATE_SPLIT) + 50'(pl_ff);
   assign inc      = PHASE_BITS'(inc_full >> INC_SHIFT);

   assign start_clear = req_ff.voice_active &&
                        (!ent_active || (ent_note != req_ff.note_number));
   assign new_phase   = start_clear ? '0 : ent_phase;
   assign slot_ok     = (32'(req_data.voice_slot) < 32'(VOICE_COUNT));

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in         = state_ff;
      vidx_in          = vidx_ff;
      valid_in         = valid_ff;
      acc_in           = acc_ff;
      rate_scale_in    = rate_scale_ff;
      buffer_length_in = buffer_length_ff;
      req_in           = req_ff;
      phase_in         = phase_ff;
      note_in          = note_ff;
      vel_in           = vel_ff;
      gain_in          = gain_ff;
      u_in             = u_ff;
      u2_in            = u2_ff;
      neg_in           = neg_ff;
      freq_in          = freq_ff;
      pl_in            = pl_ff;

      ram_we    = 1'b0;
      ram_raddr = vidx_ff;
      ram_wdata = {note_ff, vel_ff, gain_ff, 1'b1, PHASE_BITS'(phase_ff + inc)};
      mul_a     = '0;
      mul_b     = '0;
      mix.emit  = 1'b0;
      mix.sum   = acc_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_data;
               if (req_data.opcode == pvm_pkg::OP_VOICE_WRITE) begin
                  // writes to slots past the table are dropped
                  if (slot_ok) begin
                     vidx_in   = VA'(req_data.voice_slot);
                     ram_raddr = VA'(req_data.voice_slot);
                     state_in  = ST_W_UPD;
                  end
               end else begin
                  vidx_in   = '0;
                  ram_raddr = '0;
                  acc_in    = '0;
                  state_in  = ST_T_LD;
               end
            end
         end
         ST_W_UPD: begin
            ram_we    = 1'b1;
            ram_wdata = {req_ff.note_number, req_ff.note_velocity,
                         req_ff.instrument_gain, req_ff.voice_active, new_phase};
            state_in  = ST_IDLE;
         end
         ST_T_LD: begin
            if (ent_active) begin
               phase_in = ent_phase;
               note_in  = ent_note;
               vel_in   = ent_vel;
               gain_in  = ent_gain;
               u_in     = u_fold;
               neg_in   = quad[1];
               freq_in  = pvm_pkg::note_freq_q8(ent_note);
               state_in = ST_UU;
            end else if (vidx_ff == LAST_VOICE) begin
               state_in = ST_EMIT;
            end else begin
               vidx_in   = vidx_ff + VA'(1);
               ram_raddr = vidx_ff + VA'(1);
            end
         end
         ST_UU: begin
            mul_a    = MW'(u_ff);
            mul_b    = MW'(u_ff);
            state_in = ST_CU;
         end
         ST_CU: begin
            u2_in    = p15;
            mul_a    = MW'(pvm_pkg::SIN_C);
            mul_b    = MW'(p15);
            state_in = ST_TU2;
         end
         ST_TU2: begin
            mul_a    = MW'(pvm_pkg::SIN_B - p15);
            mul_b    = MW'(u2_ff);
            state_in = ST_TU;
         end
         ST_TU: begin
            mul_a    = MW'(pvm_pkg::SIN_A - p15);
            mul_b    = MW'(u_ff);
            state_in = ST_YV;
         end
         ST_YV: begin
            mul_a    = MW'(y_clamp);
            mul_b    = MW'(vel_ff);
            state_in = ST_PG;
         end
         ST_PG: begin
            mul_a    = MW'(prod[21:0]);
            mul_b    = MW'(gain_ff);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            mul_a    = MW'(prod[37:pvm_pkg::TERM_PRE_SHIFT]);
            mul_b    = pvm_pkg::TERM_RECIP;
            state_in = ST_FL;
         end
         ST_FL: begin
            acc_in   = neg_ff ? (acc_ff - $signed({10'd0, term_mag}))
                              : (acc_ff + $signed({10'd0, term_mag}));
            mul_a    = MW'(freq_ff);
            mul_b    = MW'(rate_scale_ff[pvm_pkg::RATE_SPLIT-1:0]);
            state_in = ST_FH;
         end
         ST_FH: begin
            pl_in    = prod[35:0];
            mul_a    = MW'(freq_ff);
            mul_b    = MW'(rate_scale_ff[27:pvm_pkg::RATE_SPLIT]);
            state_in = ST_WB;
         end
         ST_WB: begin
            ram_we = 1'b1;
            if (vidx_ff == LAST_VOICE) begin
               state_in = ST_EMIT;
            end else begin
               vidx_in   = vidx_ff + VA'(1);
               ram_raddr = vidx_ff + VA'(1);
               state_in  = ST_T_LD;
            end
         end
         ST_EMIT: begin
            mix.emit = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (ram_we) begin
         valid_in[vidx_ff] = 1'b1;
      end

      if (csr_we) begin
         case (csr_index)
            pvm_pkg::CSR_RATE_SCALE:    rate_scale_in    = csr_wdata[27:0];
            pvm_pkg::CSR_BUFFER_LENGTH: buffer_length_in = csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         vidx_ff          <= '0;
         valid_ff         <= '0;
         acc_ff           <= '0;
         rate_scale_ff    <= pvm_pkg::RATE_SCALE_RESET;
         buffer_length_ff <= pvm_pkg::BUFFER_LENGTH_RESET;
      end else begin
         state_ff         <= state_in;
         vidx_ff          <= vidx_in;
         valid_ff         <= valid_in;
         acc_ff           <= acc_in;
         rate_scale_ff    <= rate_scale_in;
         buffer_length_ff <= buffer_length_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      phase_ff <= phase_in;
      note_ff  <= note_in;
      vel_ff   <= vel_in;
      gain_ff  <= gain_in;
      u_ff     <= u_in;
      u2_ff    <= u2_in;
      neg_ff   <= neg_in;
      freq_ff  <= freq_in;
      pl_ff    <= pl_in;
   end

endmodule

`default_nettype wire

>>> rtl/core/pvm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the voice table. No dependencies.
`default_nettype none

module pvm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 we,
   input  wire logic [AW-1:0]        waddr,
   input  wire logic [WIDTH-1:0]     wdata,
   input  wire logic [AW-1:0]        raddr,
   output logic      [WIDTH-1:0]     rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> rtl/core/pvm_mul.sv
// Shared 32x32 unsigned multiplier with a registered product.
// Depends on pvm_pkg for the operand width.
`default_nettype none

module pvm_mul (
   input  wire logic                          clock,
   input  wire logic [pvm_pkg::MUL_BITS-1:0]  a,
   input  wire logic [pvm_pkg::MUL_BITS-1:0]  b,
   output logic      [2*pvm_pkg::MUL_BITS-1:0] prod
);

   logic [2*pvm_pkg::MUL_BITS-1:0] prod_ff;
   logic [2*pvm_pkg::MUL_BITS-1:0] prod_in;

   assign prod_in = (2*pvm_pkg::MUL_BITS)'(a) * (2*pvm_pkg::MUL_BITS)'(b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

>>> rtl/core/pvm_out_stage.sv
// Output stage: clamps the mix sum, scales it to 16-bit PCM and tracks
// the buffer position. Depends on pvm_pkg.
`default_nettype none

module pvm_out_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire pvm_pkg::mix_req_type  mix,
   input  wire logic [12:0]           buffer_length,
   output logic                       rsp_valid,
   output pvm_pkg::rsp_type           rsp_data
);

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   pvm_pkg::rsp_type   rsp_data_ff;
   pvm_pkg::rsp_type   rsp_data_in;
   logic [11:0]        pos_ff;
   logic [11:0]        pos_in;

   logic signed [31:0] clamped;
   logic               neg;
   logic [31:0]        mag_w;
   logic [24:0]        mag;
   logic [39:0]        scaled;
   logic [14:0]        pcm_mag;
   logic [12:0]        len;
   logic [12:0]        pos_next;
   logic               last;

   always_comb begin
      if (mix.sum > pvm_pkg::ONE_Q24) begin
         clamped = pvm_pkg::ONE_Q24;
      end else if (mix.sum < -pvm_pkg::ONE_Q24) begin
         clamped = -pvm_pkg::ONE_Q24;
      end else begin
         clamped = mix.sum;
      end
      neg     = clamped[31];
      mag_w   = neg ? 32'(-clamped) : 32'(clamped);
      mag     = mag_w[24:0];
      // times 32767 = times 2^15 minus one
      scaled  = {mag, 15'd0} - 40'(mag);
      pcm_mag = scaled[38:24];

      if (buffer_length == 13'd0) begin
         len = 13'd1;
      end else if (buffer_length > pvm_pkg::BUFFER_LENGTH_MAX) begin
         len = pvm_pkg::BUFFER_LENGTH_MAX;
      end else begin
         len = buffer_length;
      end
      pos_next = 13'(pos_ff) + 13'd1;
      last     = (pos_next >= len);

      rsp_valid_in = mix.emit;
      rsp_data_in  = rsp_data_ff;
      pos_in       = pos_ff;
      if (mix.emit) begin
         rsp_data_in.pcm_sample    = neg ? (16'sd0 - $signed({1'b0, pcm_mag}))
                                         : $signed({1'b0, pcm_mag});
         rsp_data_in.end_of_buffer = last;
         pos_in                    = last ? 12'd0 : pos_next[11:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pos_ff       <= 12'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/pvm_checker.sv
// Port-level checks for the voice mixer top level, plus the bind that
// attaches them. Depends on pvm_pkg and polyphonic_sine_voice_mixer_unit.
`default_nettype none

module pvm_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire pvm_pkg::req_type  req_data,
   input wire logic              rsp_valid,
   input wire pvm_pkg::rsp_type  rsp_data
);

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe after reset");

   // a tick goes through ST_T_LD before ST_EMIT, so strobes never touch
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back result strobes");

   // a taken tick keeps the block busy and cannot answer at once
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.opcode == pvm_pkg::OP_TICK) |=> (busy && !rsp_valid))
      else $error("tick transaction not held busy");

   // clamp is symmetric, most negative code never appears
   a_pcm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.pcm_sample != 16'sh8000))
      else $error("pcm sample out of range");

endmodule

bind polyphonic_sine_voice_mixer_unit pvm_checker u_pvm_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire

>>> dv/polyphonic_sine_voice_mixer_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for polyphonic_sine_voice_mixer_unit: voice writes and
// sample ticks go in, every emitted sample is checked against a local oscillator-bank model or a directed value.
// Depends on pvm_pkg (ports, opcodes, register indexes) and the mixer RTL.
module polyphonic_sine_voice_mixer_unit_tb;
   import pvm_pkg::*;

   localparam int VOICES         = 16;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 200;
   localparam int SETTLE_CYCLES  = 4;
   localparam int PHASES         = 8;
   localparam int ITEMS_PER_PHASE = 178;
   localparam int MAX_GAP        = 40;
   localparam longint unsigned TERM_DIVISOR = 64'd81280;
   localparam longint signed   FULL_SCALE   = 64'sd16777216;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_3 = 2'd3;

   typedef struct {
      logic [6:0]  note;
      logic [6:0]  velocity;
      logic [15:0] gain;
      logic        active;
      logic [31:0] phase;
   } voice_t;

   typedef struct {
      req_type item;
      logic    typed;
      rsp_type want;
   } stim_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   // model state
   voice_t voices [VOICES];
   logic [27:0] rate_reg;
   logic [12:0] buflen_reg;
   logic [11:0] buf_pos;

   rsp_type sample_queue [$];
   stim_row_t directed_rows [$];
   int fail_count = 0;
   int idle_pct = 0;
   int quiet_cycles = 0;

   polyphonic_sine_voice_mixer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Q8 note frequency: top octave entry, shifted down by octave with round half up
   function automatic longint unsigned note_freq(input logic [6:0] note);
      int octave;
      int shift;
      longint unsigned top;
      octave = note / 12;
      shift = 10 - octave;
      case (note % 12)
         0: top = 64'd2143237;
         1: top = 64'd2270680;
         2: top = 64'd2405702;
         3: top = 64'd2548752;
         4: top = 64'd2700309;
         5: top = 64'd2860878;
         6: top = 64'd3030994;
         7: top = 64'd3211227;
         8: top = 64'd3402176;
         9: top = 64'd3604480;
         10: top = 64'd3818814;
         default: top = 64'd4045892;
      endcase
      if (shift == 0)
         return top;
      return (top + (64'd1 << (shift - 1))) >> shift;
   endfunction

   // Q1.15 sine from quarter-wave fold and odd polynomial
   function automatic longint signed sine_at(input logic [9:0] idx);
      longint unsigned u;
      longint unsigned u2;
      longint unsigned t;
      longint unsigned y;
      u = 64'(idx[7:0]) << 7;
      if (idx[8])
         u = 64'd32768 - u;
      u2 = (u * u) >> 15;
      t = (64'd2320 * u2) >> 15;
      t = 64'd21024 - t;
      t = (t * u2) >> 15;
      t = 64'd51472 - t;
      y = (t * u) >> 15;
      if (y > 64'd32767)
         y = 64'd32767;
      return idx[9] ? -signed'(y) : signed'(y);
   endfunction

   // Applies one transaction to the model; returns 1 with the sample for a tick.
   function automatic bit mix_step(input req_type item, output rsp_type sample);
      longint signed total;
      longint signed s;
      longint unsigned mag;
      longint unsigned inc;
      logic [15:0] pcm16;
      logic [3:0] slot;
      int len;
      logic last;
      sample = '0;
      if (item.opcode == OP_VOICE_WRITE) begin
         slot = item.voice_slot;
         // a start or a note change restarts the oscillator
         if (item.voice_active &&
             (!voices[slot].active || voices[slot].note != item.note_number))
            voices[slot].phase = '0;
         voices[slot].note     = item.note_number;
         voices[slot].velocity = item.note_velocity;
         voices[slot].gain     = item.instrument_gain;
         voices[slot].active   = item.voice_active;
         return 1'b0;
      end
      total = 0;
      for (int i = 0; i < VOICES; i++) begin
         if (voices[i].active) begin
            s = sine_at(voices[i].phase[31:22]);
            mag = 64'(s < 0 ? -s : s);
            mag = mag * voices[i].velocity * voices[i].gain / TERM_DIVISOR;
            if (s < 0)
               total -= signed'(mag);
            else
               total += signed'(mag);
            inc = (note_freq(voices[i].note) * 64'(rate_reg)) >> 16;
            voices[i].phase = voices[i].phase + inc[31:0];
         end
      end
      if (total > FULL_SCALE)
         total = FULL_SCALE;
      if (total < -FULL_SCALE)
         total = -FULL_SCALE;
      mag = unsigned'(total < 0 ? -total : total);
      mag = (mag * 64'd32767) >> 24;
      pcm16 = mag[15:0];
      if (total < 0)
         pcm16 = -pcm16;
      len = int'(buflen_reg);
      if (len == 0)
         len = 1;
      if (len > 4096)
         len = 4096;
      last = (int'(buf_pos) + 1 >= len);
      buf_pos = last ? 12'd0 : buf_pos + 12'd1;
      sample.pcm_sample    = pcm16;
      sample.end_of_buffer = last;
      return 1'b1;
   endfunction

   function automatic stim_row_t stim_row(input logic op, input int slot, input int note,
                                          input int vel, input int gain, input logic act);
      stim_row_t row;
      row.item.opcode          = op;
      row.item.voice_slot      = 4'(slot);
      row.item.note_number     = 7'(note);
      row.item.note_velocity   = 7'(vel);
      row.item.instrument_gain = 16'(gain);
      row.item.voice_active    = act;
      row.typed = 1'b0;
      row.want  = '0;
      return row;
   endfunction

   function automatic req_type random_item();
      req_type r;
      r.opcode          = ($urandom_range(99) < 40) ? OP_VOICE_WRITE : OP_TICK;
      r.voice_slot      = 4'($urandom_range(15));
      r.note_number     = 7'($urandom_range(127));
      // half the writes keep the slot's note so the phase carries over
      if (r.opcode == OP_VOICE_WRITE && $urandom_range(1) == 1)
         r.note_number = voices[r.voice_slot].note;
      case ($urandom_range(9))
         0: r.note_velocity = 7'd0;
         1: r.note_velocity = 7'd127;
         default: r.note_velocity = 7'($urandom_range(127));
      endcase
      case ($urandom_range(9))
         0: r.instrument_gain = 16'd0;
         1: r.instrument_gain = 16'hFFFF;
         default: r.instrument_gain = 16'($urandom_range(65535));
      endcase
      r.voice_active = ($urandom_range(99) < 65);
      return r;
   endfunction

   // Presents one transaction and returns at the edge that takes it.
   task automatic issue_item(input req_type item);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
         gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
   endtask

   task automatic quiesce(input int extra);
      start <= 1'b0;
      while (sample_queue.size() != 0)
         @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   // Writes both registers plus the two unused indexes, which must be ignored.
   task automatic configure(input logic [27:0] rate, input logic [27:0] buf_word);
      logic [CSR_INDEX_BITS-1:0] idx [4];
      logic [CSR_DATA_BITS-1:0] val [4];
      idx[0] = CSR_RATE_SCALE;    val[0] = rate;
      idx[1] = CSR_BUFFER_LENGTH; val[1] = buf_word;
      idx[2] = CSR_SPARE_2;       val[2] = 28'($urandom);
      idx[3] = CSR_SPARE_3;       val[3] = 28'($urandom);
      for (int k = 0; k < 4; k++) begin
         csr_we <= 1'b1;
         csr_index <= idx[k];
         csr_wdata <= val[k];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      rate_reg = rate;
      buflen_reg = buf_word[12:0];
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if ((start && !busy) || rsp_valid)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end else if (rsp_valid) begin
            if (sample_queue.size() == 0) begin
               $error("rsp: unexpected sample %0d", rsp_data.pcm_sample);
               fail_count++;
            end else begin
               want = sample_queue.pop_front();
               if (rsp_data.pcm_sample !== want.pcm_sample) begin
                  $error("pcm_sample: expected %0d, got %0d",
                         want.pcm_sample, rsp_data.pcm_sample);
                  fail_count++;
               end
               if (rsp_data.end_of_buffer !== want.end_of_buffer) begin
                  $error("end_of_buffer: expected %0b, got %0b",
                         want.end_of_buffer, rsp_data.end_of_buffer);
                  fail_count++;
               end
            end
         end
      end
   end

   initial begin
      stim_row_t row;
      req_type item;
      rsp_type sample;
      logic [27:0] rate;
      logic [27:0] buf_word;

      for (int i = 0; i < VOICES; i++)
         voices[i] = '{7'd0, 7'd0, 16'd0, 1'b0, 32'd0};
      rate_reg = RATE_SCALE_RESET;
      buflen_reg = BUFFER_LENGTH_RESET;
      buf_pos = '0;

      // silent bank right after reset
      row = stim_row(OP_TICK, 0, 0, 0, 0, 1'b0);
      row.typed = 1'b1;
      row.want = '0;
      directed_rows.push_back(row);
      // seven full-scale voices in step drive the sum into both clamps
      for (int v = 0; v < 7; v++)
         directed_rows.push_back(stim_row(OP_VOICE_WRITE, v, 127, 127, 65535, 1'b1));
      directed_rows.push_back(stim_row(OP_VOICE_WRITE, 15, 0, 1, 1, 1'b1));
      directed_rows.push_back(stim_row(OP_TICK, 15, 127, 127, 65535, 1'b1));
      for (int k = 0; k < 5; k++)
         directed_rows.push_back(stim_row(OP_TICK, 0, 0, 0, 0, 1'b0));
      // same note while active keeps phase; new note restarts it
      directed_rows.push_back(stim_row(OP_VOICE_WRITE, 0, 127, 64, 32768, 1'b1));
      directed_rows.push_back(stim_row(OP_VOICE_WRITE, 1, 60, 127, 65535, 1'b1));
      directed_rows.push_back(stim_row(OP_VOICE_WRITE, 2, 127, 0, 0, 1'b0));
      directed_rows.push_back(stim_row(OP_TICK, 0, 0, 0, 0, 1'b0));
      directed_rows.push_back(stim_row(OP_VOICE_WRITE, 2, 127, 127, 65535, 1'b1));
      directed_rows.push_back(stim_row(OP_VOICE_WRITE, 3, 127, 127, 65535, 1'b0));
      directed_rows.push_back(stim_row(OP_TICK, 0, 0, 0, 0, 1'b0));
      // restart from inactive with an unchanged note
      directed_rows.push_back(stim_row(OP_VOICE_WRITE, 3, 127, 127, 65535, 1'b1));
      directed_rows.push_back(stim_row(OP_TICK, 0, 0, 0, 0, 1'b0));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         issue_item(directed_rows[r].item);
         if (mix_step(directed_rows[r].item, sample))
            sample_queue.push_back(directed_rows[r].typed ? directed_rows[r].want : sample);
      end

      for (int p = 0; p < PHASES; p++) begin
         quiesce(SETTLE_CYCLES);
         case (p)
            0: begin rate = 28'd0;           buf_word = 28'd1;         end
            1: begin rate = 28'hFFFFFFF;     buf_word = 28'd0;         end
            2: begin rate = 28'd10956780;    buf_word = 28'hFFFFFFF;   end
            3: begin rate = 28'($urandom);   buf_word = 28'd4096;      end
            // shrinks below the current position
            4: begin rate = 28'd1;           buf_word = 28'd7;         end
            5: begin rate = RATE_SCALE_RESET; buf_word = 28'd4097;     end
            default: begin
               rate = 28'($urandom);
               buf_word = 28'($urandom_range(40, 1));
            end
         endcase
         configure(rate, buf_word);
         case (p % 4)
            1: idle_pct = 76;
            3: idle_pct = 29;
            default: idle_pct = 0;
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            item = random_item();
            issue_item(item);
            if (mix_step(item, sample))
               sample_queue.push_back(sample);
         end
      end

      quiesce(DRAIN_CYCLES);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/pvm_pkg.sv
rtl/core/pvm_ram.sv
rtl/core/pvm_mul.sv
rtl/core/pvm_out_stage.sv
rtl/core/polyphonic_sine_voice_mixer_unit.sv
rtl/core/pvm_checker.sv
dv/polyphonic_sine_voice_mixer_unit_tb.sv
